/* rtl/pli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int KEY_W   = 17;                  // q1.16 key and value width
	localparam int ACT_W   = 2;
	localparam int PROD_W  = 2 * KEY_W;           // num * delta
	localparam int IN_DW   = ((2 * KEY_W + 7) / 8) * 8;
	localparam int OUT_DW  = ((KEY_W + 7) / 8) * 8;
	localparam logic [KEY_W-1:0] Q_ONE  = 17'h10000;
	localparam logic [KEY_W-1:0] Q_ZERO = 17'h00000;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_EVAL   = 2'd2
	} action_t;

endpackage

/* rtl/pli_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_ram
// Generic simple dual port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pli_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/pli_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_div #(
	parameter int N_W = 34,
	parameter int D_W = 17
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic             fits;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so D_W bits hold it
			rem_q <= fits ? D_W'(trial - {1'b0, dvs_q}) : trial[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");
`endif

endmodule

/* rtl/piecewise_linear_interpolator.sv */
`timescale 1ns / 1ps
// clear, append and evaluate with fewer than two points go straight to the done state
// evaluate with n stored points makes two scans of the table through the single ram
// read port, then reads the segment ends and may run 34 steps of the serial divider
// one item is in flight at a time; a finished result may wait in the output reg
// reset clears the point count; table contents stay undefined, no clearing pass
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Control point table in ram with clamped segment search and linear interp.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator
	import pli_pkg::*;
#(
	parameter int MAX_POINTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_DW-1:0]  s_axis_tdata,  // key_position, point_value, zero pad
	input  logic [ACT_W-1:0]  s_axis_tuser,  // action
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_DW-1:0] m_axis_tdata,  // result_value, zero pad
	output logic [0:0]        m_axis_tuser   // status
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RANGE = 9'b000000010,
		ST_SEG   = 9'b000000100,
		ST_RD0   = 9'b000001000,
		ST_RD1   = 9'b000010000,
		ST_RD2   = 9'b000100000,
		ST_MUL   = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_idx_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic [AW-1:0]     seg_q;
	logic [KEY_W-1:0]  q_q, lo_q, hi_q;
	logic [KEY_W-1:0]  k0_q, v0_q;
	logic [KEY_W-1:0]  num_q, gap_q, mag_q;
	logic              neg_q;
	logic [KEY_W-1:0]  res_q;
	logic              st_q;
	logic              out_vld_q;
	logic [KEY_W-1:0]  out_res_q;
	logic              out_st_q;

	logic              s_fire;
	action_t           act;
	logic [KEY_W-1:0]  in_key, in_val;
	logic              scanning, issue;
	logic [AW-1:0]     raddr;
	logic [2*KEY_W-1:0] rdata;
	logic [KEY_W-1:0]  rd_key, rd_val;
	logic [KEY_W-1:0]  q_lo, q_clamp;
	logic              full;
	logic              out_free;
	logic              div_start, div_done;
	logic [PROD_W-1:0] div_quo;

	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign act      = action_t'(s_axis_tuser);
	assign in_key   = s_axis_tdata[KEY_W-1:0];
	assign in_val   = s_axis_tdata[2*KEY_W-1:KEY_W];
	assign full     = count_q == CW'(MAX_POINTS);
	assign out_free = !out_vld_q || m_axis_tready;

	assign scanning = (state_q == ST_RANGE) || (state_q == ST_SEG);
	assign issue    = scanning && (rd_idx_q < count_q);
	assign rd_key   = rdata[KEY_W-1:0];
	assign rd_val   = rdata[2*KEY_W-1:KEY_W];

	assign q_lo    = (q_q < lo_q) ? lo_q : q_q;
	assign q_clamp = (q_lo > hi_q) ? hi_q : q_lo;

	always_comb begin
		unique case (state_q)
			ST_RD0:  raddr = seg_q;
			ST_RD1:  raddr = seg_q + 1'b1;
			default: raddr = rd_idx_q[AW-1:0];
		endcase
	end

	pli_ram #(
		.WIDTH (2 * KEY_W),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (s_fire && act == ACT_APPEND && !full),
		.waddr (count_q[AW-1:0]),
		.wdata ({in_val, in_key}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign div_start = state_q == ST_MUL;

	pli_div #(
		.N_W (PROD_W),
		.D_W (KEY_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (PROD_W'(num_q) * PROD_W'(mag_q)),
		.divisor  (gap_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						rd_idx_q <= '0;
						if (act == ACT_EVAL && count_q >= CW'(2)) begin
							state_q <= ST_RANGE;
						end else begin
							state_q <= ST_DONE;
						end
						case (act)
							ACT_CLEAR:  count_q <= '0;
							ACT_APPEND: if (!full) count_q <= count_q + 1'b1;
							default:    ;
						endcase
					end
				end
				ST_RANGE: begin
					if (!issue && !rd_vld_s1) begin
						rd_idx_q <= '0;
						state_q  <= ST_SEG;
					end
				end
				ST_SEG: begin
					if (!issue && !rd_vld_s1) begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= (CW'(seg_q) == count_q - 1'b1) ? ST_DONE : ST_RD2;
				ST_RD2: begin
					if (rd_key <= k0_q || q_q < k0_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: if (div_done) state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				q_q   <= in_key;
				lo_q  <= Q_ONE;
				hi_q  <= Q_ZERO;
				seg_q <= '0;
				st_q  <= (act == ACT_APPEND) && full;
				// pass-through covers evaluate with fewer than two points
				res_q <= (act == ACT_EVAL) ? in_key : Q_ZERO;
			end
			ST_RANGE: begin
				if (rd_vld_s1) begin
					if (rd_key < lo_q) lo_q <= rd_key;
					if (rd_key > hi_q) hi_q <= rd_key;
				end else if (!issue) begin
					q_q <= q_clamp;
				end
			end
			ST_SEG: begin
				// ascending scan, the last match wins
				if (rd_vld_s1 && rd_key <= q_q) seg_q <= rd_idx_s1;
			end
			ST_RD1: begin
				k0_q  <= rd_key;
				v0_q  <= rd_val;
				res_q <= rd_val;
			end
			ST_RD2: begin
				num_q <= q_q - k0_q;
				gap_q <= rd_key - k0_q;
				neg_q <= rd_val < v0_q;
				mag_q <= (rd_val < v0_q) ? v0_q - rd_val : rd_val - v0_q;
			end
			ST_DIV: begin
				res_q <= neg_q ? v0_q - div_quo[KEY_W-1:0] : v0_q + div_quo[KEY_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					out_res_q <= res_q;
					out_st_q  <= st_q;
				end
			end
			default: ;
		endcase
		rd_idx_s1 <= rd_idx_q[AW-1:0];
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_DW'(out_res_q);
	assign m_axis_tuser  = out_st_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS)) else $error("point count above table depth");
	a_count_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(s_fire)) else $error("point count moved without a beat");
	a_seg_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD0 || state_q == ST_RD1 || state_q == ST_RD2) |-> CW'(seg_q) < count_q)
		else $error("segment start beyond stored points");
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("divider finished outside divide state");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_free) |=> state_q == ST_DONE)
		else $error("result dropped while output stalled");
`endif

endmodule
